@@ rtl/nsc_pkg.sv @@
// Shared types, constants and helper functions for the NMEA sentence checker.
package nsc_pkg;

    localparam int FIELD_LIMIT_DEF  = 20;
    localparam int MAX_SENTENCE_DEF = 128;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD      = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_C     = 8'h43;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_rmc;
        logic [7:0]  fix_char;
        logic [15:0] speed_whole;
        logic [15:0] course_whole;
        logic [4:0]  field_total;
        logic [7:0]  sum_seen;
    } nsc_result_t;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_COMMA) || (c == CH_STAR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // {valid, value} of one hex character, upper or lower case
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // acc * 10 + d, saturated at the 16-bit maximum
    function automatic logic [15:0] add_digit(input logic [15:0] acc, input logic [3:0] d);
        logic [19:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {16'd0, d};
        return (v > 20'd65535) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

@@ rtl/nsc_channels.sv @@
// Handshake channel interfaces: sentence characters in, sentence reports out.
interface nsc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_flag;

    modport source (output valid, output data_byte, output end_flag, input ready);
    modport sink (input valid, input data_byte, input end_flag, output ready);
endinterface

interface nsc_report_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        is_rmc;
    logic [7:0]  fix_char;
    logic [15:0] speed_whole;
    logic [15:0] course_whole;
    logic [4:0]  field_total;
    logic [7:0]  sum_seen;

    modport source (output valid, output status, output is_rmc, output fix_char,
                    output speed_whole, output course_whole, output field_total,
                    output sum_seen, input ready);
    modport sink (input valid, input status, input is_rmc, input fix_char,
                  input speed_whole, input course_whole, input field_total,
                  input sum_seen, output ready);
endinterface

@@ rtl/nmea_sentence_checker.sv @@
// Top level of the NMEA sentence checker: input register, parser, report register.
//
// Feed an NMEA 0183 sentence one character per transfer on chars, starting
// with the leading '$', and raise end_flag on its final character. The block
// runs the XOR checksum over the body (everything after '$' up to but not
// including '*' and the two hex digits), checks it against the trailing hex
// pair, counts ',' and '*' separators and recognizes the RMC type. On the
// final character it emits one report transfer: status 0 ok, 1 checksum
// mismatch or a sentence shorter than 4 or longer than MAX_SENTENCE
// characters, 2 more separators than FIELD_LIMIT allows. For a valid RMC
// sentence the report also carries the status letter and the integer parts
// of speed and course (saturated at 65535); for anything else those read 0.
// Characters that are not the last produce no report. The block takes one
// character per clock cycle while input is not stalled: a character is held in
// the input register, the parser updates its state from it in a single step,
// and the report is registered in the report register. A waiting report
// stalls input only when another final character needs the register;
// ordinary characters keep flowing while the report waits.
module nmea_sentence_checker #(
    parameter int FIELD_LIMIT  = nsc_pkg::FIELD_LIMIT_DEF,
    parameter int MAX_SENTENCE = nsc_pkg::MAX_SENTENCE_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    nsc_char_if.sink     chars,
    nsc_report_if.source reports
);
    import nsc_pkg::*;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    // report register
    logic        out_valid_reg;
    nsc_result_t out_reg;

    nsc_result_t step_result;
    logic        advance;

    // Advance the held character unless it is a final one and the report
    // register is still occupied by an untaken report.
    assign advance     = in_valid_reg && (!in_end_reg || !out_valid_reg || reports.ready);
    assign chars.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.ready) begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready) begin
            in_byte_reg <= chars.data_byte;
            in_end_reg  <= chars.end_flag;
        end
    end

    nsc_parser #(
        .FIELD_LIMIT  (FIELD_LIMIT),
        .MAX_SENTENCE (MAX_SENTENCE)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .end_flag  (in_end_reg),
        .result    (step_result)
    );

    // Hold the report until it is taken; load a new one on a final character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_end_reg) begin
            out_valid_reg <= 1'b1;
        end
        else if (reports.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_end_reg) begin
            out_reg <= step_result;
        end
    end

    assign reports.valid        = out_valid_reg;
    assign reports.status       = out_reg.status;
    assign reports.is_rmc       = out_reg.is_rmc;
    assign reports.fix_char     = out_reg.fix_char;
    assign reports.speed_whole  = out_reg.speed_whole;
    assign reports.course_whole = out_reg.course_whole;
    assign reports.field_total  = out_reg.field_total;
    assign reports.sum_seen     = out_reg.sum_seen;

endmodule

@@ rtl/nsc_parser.sv @@
// Per-sentence parse state and the single-step update for one character.
module nsc_parser #(
    parameter int FIELD_LIMIT  = nsc_pkg::FIELD_LIMIT_DEF,
    parameter int MAX_SENTENCE = nsc_pkg::MAX_SENTENCE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                end_flag,
    output nsc_pkg::nsc_result_t result
);
    import nsc_pkg::*;

    localparam int POS_W   = $clog2(MAX_SENTENCE + 2);
    localparam int SEP_CAP = (FIELD_LIMIT + 1 > 31) ? 31 : FIELD_LIMIT + 1;
    localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_SENTENCE + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_SENTENCE);

    logic [7:0]       xor_reg,      xor_next;
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [23:0]      tail_reg,     tail_next;
    logic [4:0]       sep_reg,      sep_next;
    logic [2:0]       type_reg,     type_next;
    logic [7:0]       letter_reg,   letter_next;
    logic [15:0]      speed_reg,    speed_next;
    logic [15:0]      course_reg,   course_next;
    logic [1:0]       open_reg,     open_next;
    logic             ovf_reg,      ovf_next;

    logic [4:0] hi_dec;
    logic [4:0] lo_dec;
    logic       bad;
    logic       rmc;
    logic [1:0] status;

    always_comb
    begin
        xor_next    = (pos_reg >= POS_W'(4)) ? (xor_reg ^ tail_reg[23:16]) : xor_reg;
        tail_next   = {tail_reg[15:0], data_byte};
        type_next   = type_reg;
        sep_next    = sep_reg;
        ovf_next    = ovf_reg;
        letter_next = letter_reg;
        speed_next  = speed_reg;
        course_next = course_reg;
        open_next   = open_reg;

        if (pos_reg == POS_W'(3) && data_byte != CH_R) type_next[0] = 1'b0;
        if (pos_reg == POS_W'(4) && data_byte != CH_M) type_next[1] = 1'b0;
        if (pos_reg == POS_W'(5) && data_byte != CH_C) type_next[2] = 1'b0;

        if (is_sep(data_byte)) begin
            if (sep_reg >= 5'(FIELD_LIMIT)) ovf_next = 1'b1;
            if (sep_reg < 5'(SEP_CAP)) sep_next = sep_reg + 5'd1;
        end
        else begin
            // first character right after the second separator
            if (sep_reg == 5'd2 && is_sep(tail_reg[7:0])) letter_next = data_byte;
            if (sep_reg == 5'd7 && open_reg[0]) begin
                if (is_digit(data_byte)) speed_next = add_digit(speed_reg, data_byte[3:0]);
                else open_next[0] = 1'b0;
            end
            if (sep_reg == 5'd8 && open_reg[1]) begin
                if (is_digit(data_byte)) course_next = add_digit(course_reg, data_byte[3:0]);
                else open_next[1] = 1'b0;
            end
        end

        pos_next = (pos_reg < POS_SAT) ? pos_reg + POS_W'(1) : pos_reg;

        hi_dec = hex_decode(tail_next[15:8]);
        lo_dec = hex_decode(tail_next[7:0]);
        bad = (pos_next < POS_W'(4)) || (pos_next > POS_MAX) || !hi_dec[4] || !lo_dec[4]
              || ({hi_dec[3:0], lo_dec[3:0]} != xor_next);
        if (bad) status = STATUS_BAD;
        else if (ovf_next) status = STATUS_OVERFLOW;
        else status = STATUS_OK;

        rmc = (status == STATUS_OK) && (pos_next >= POS_W'(6)) && (type_next == 3'b111);

        result.status       = status;
        result.is_rmc       = rmc;
        result.fix_char     = rmc ? letter_next : 8'd0;
        result.speed_whole  = rmc ? speed_next : 16'd0;
        result.course_whole = rmc ? course_next : 16'd0;
        result.field_total  = sep_next;
        result.sum_seen     = xor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            xor_reg    <= '0;
            pos_reg    <= '0;
            tail_reg   <= '0;
            sep_reg    <= '0;
            type_reg   <= 3'b111;
            letter_reg <= '0;
            speed_reg  <= '0;
            course_reg <= '0;
            open_reg   <= 2'b11;
            ovf_reg    <= 1'b0;
        end
        else if (step) begin
            if (end_flag) begin
                // sentence done: drop all state back to the start condition
                xor_reg    <= '0;
                pos_reg    <= '0;
                tail_reg   <= '0;
                sep_reg    <= '0;
                type_reg   <= 3'b111;
                letter_reg <= '0;
                speed_reg  <= '0;
                course_reg <= '0;
                open_reg   <= 2'b11;
                ovf_reg    <= 1'b0;
            end
            else begin
                xor_reg    <= xor_next;
                pos_reg    <= pos_next;
                tail_reg   <= tail_next;
                sep_reg    <= sep_next;
                type_reg   <= type_next;
                letter_reg <= letter_next;
                speed_reg  <= speed_next;
                course_reg <= course_next;
                open_reg   <= open_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

endmodule

@@ verif/nmea_sentence_checker_tb.sv @@
// Self-checking testbench for the NMEA sentence checker: directed and random sentences.
module nmea_sentence_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nsc_pkg::*;

    localparam int FIELD_LIMIT        = FIELD_LIMIT_DEF;
    localparam int MAX_SENTENCE       = MAX_SENTENCE_DEF;
    // the separator count stops one past the field limit, never above 5 bits
    localparam int SEP_CAP            = (FIELD_LIMIT + 1 > 31) ? 31 : FIELD_LIMIT + 1;
    localparam int RANDOM_CHARS       = 640;
    // clocks to run on after the last report has come back
    localparam int SETTLE_CYCLES      = 8;
    localparam int CYCLE_LIMIT        = 500000;
    localparam int NO_TYPED           = -1;

    // how a sentence is closed: left as typed, or '*' plus a checksum pair
    typedef enum {SEAL_NONE, SEAL_UPPER, SEAL_LOWER, SEAL_WRONG, SEAL_JUNK} seal_t;

    typedef struct {
        string text;
        string fill;
        int    fill_count;
        seal_t seal;
        int    want_status;
    } directed_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    nsc_char_if   chars_if ();
    nsc_report_if reports_if ();

    nmea_sentence_checker DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .reports (reports_if)
    );

    always #1 clk = ~clk;

    // Parser state mirrored by the predictor
    logic [7:0]  sum_acc;
    logic [10:0] char_pos;
    logic [23:0] last_three;
    logic [4:0]  sep_total;
    logic [2:0]  type_hits;
    logic [7:0]  fix_letter;
    logic [15:0] speed_run;
    logic [15:0] course_run;
    logic [1:0]  number_open;
    logic        too_many_fields;

    nsc_result_t predicted_reports [$];
    logic [7:0]  sentence [$];

    int  error_count   = 0;
    int  chars_sent    = 0;
    int  cycle_count   = 0;
    bit  sender_steady = 1'b0;
    bit  sink_steady   = 1'b0;

    // Directed sentences. A typed status is checked in place of the predicted one.
    directed_row_t directed_rows [21] = '{
        // full RMC right after reset
        '{"$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W",
          "", 0, SEAL_UPPER, int'(STATUS_OK)},
        // same sentence, lower-case checksum digits
        '{"$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W",
          "", 0, SEAL_LOWER, NO_TYPED},
        // every field empty but the status letter
        '{"$GPRMC,,V,,,,,,,,,", "", 0, SEAL_UPPER, NO_TYPED},
        // empty status, a sign before speed, a space before course
        '{"$GPRMC,1,,2,N,3,E,-5, 7.5,", "", 0, SEAL_UPPER, NO_TYPED},
        // speed past 16 bits saturates, course sits exactly at the top
        '{"$GNRMC,0,A,0,N,0,E,99999999,65535,", "", 0, SEAL_UPPER, NO_TYPED},
        // other sentence types report zero for the RMC fields
        '{"$GPGGA,1,A,3,N,4,E,5,6", "", 0, SEAL_UPPER, NO_TYPED},
        '{"$GPRMB,1,A,2,N,3,E,4,5", "", 0, SEAL_UPPER, NO_TYPED},
        '{"$GPRNC,1,A,2,N,3,E,4,5", "", 0, SEAL_UPPER, NO_TYPED},
        '{"$GPXMC,1,A,2,N,3,E,4,5", "", 0, SEAL_UPPER, NO_TYPED},
        // checksum errors
        '{"$GPRMC,1,A,2,N,3,E,4,5", "", 0, SEAL_WRONG, int'(STATUS_BAD)},
        '{"$GPRMC,1,A,2,N,3,E,4,5", "", 0, SEAL_JUNK, int'(STATUS_BAD)},
        // too short, then the shortest legal sentences
        '{"$", "", 0, SEAL_NONE, int'(STATUS_BAD)},
        '{"$GP", "", 0, SEAL_NONE, int'(STATUS_BAD)},
        '{"$*00", "", 0, SEAL_NONE, int'(STATUS_OK)},
        '{"$G*47", "", 0, SEAL_NONE, int'(STATUS_OK)},
        // separators right at the limit, one past it, and far past it with a bad sum
        '{"$GPRMC", ",", 19, SEAL_UPPER, int'(STATUS_OK)},
        '{"$GPRMC", ",", 20, SEAL_UPPER, int'(STATUS_OVERFLOW)},
        '{"$GPRMC", ",", 25, SEAL_WRONG, int'(STATUS_BAD)},
        // top byte value in the body
        '{"$GP\377\377,A,\377", "", 0, SEAL_UPPER, NO_TYPED},
        // exactly the longest sentence, then three characters over
        '{"$GPTXT,", "9", 118, SEAL_UPPER, int'(STATUS_OK)},
        '{"$GPTXT,", "9", 121, SEAL_UPPER, int'(STATUS_BAD)}
    };

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    task automatic clear_parser();
        sum_acc         = 8'd0;
        char_pos        = 11'd0;
        last_three      = 24'd0;
        sep_total       = 5'd0;
        type_hits       = 3'b111;
        fix_letter      = 8'd0;
        speed_run       = 16'd0;
        course_run      = 16'd0;
        number_open     = 2'b11;
        too_many_fields = 1'b0;
    endtask

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return -1;
    endfunction

    // append one decimal digit, holding at the 16-bit maximum
    function automatic logic [15:0] next_whole(input logic [15:0] acc, input logic [3:0] d);
        int v;
        v = int'(acc) * 10 + int'(d);
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    // Advance the predictor by one transferred character; queue a report on the last one.
    task automatic parse_char(input logic [7:0] ch, input logic last, input int want_status);
        logic [7:0]  prev;
        logic        sep;
        int          len;
        int          hi;
        int          lo;
        nsc_result_t rep;

        prev = last_three[7:0];
        sep  = (ch == CH_COMMA) || (ch == CH_STAR);
        // the oldest of the last three joins the checksum once it is past the '$'
        if (char_pos >= 4) sum_acc ^= last_three[23:16];
        last_three = {last_three[15:0], ch};

        if (char_pos == 3 && ch != CH_R) type_hits[0] = 1'b0;
        if (char_pos == 4 && ch != CH_M) type_hits[1] = 1'b0;
        if (char_pos == 5 && ch != CH_C) type_hits[2] = 1'b0;

        if (sep) begin
            if (sep_total >= FIELD_LIMIT) too_many_fields = 1'b1;
            if (sep_total < SEP_CAP) sep_total++;
        end
        else begin
            if (sep_total == 2 && ((prev == CH_COMMA) || (prev == CH_STAR))) fix_letter = ch;
            if (sep_total == 7 && number_open[0]) begin
                if (ch >= "0" && ch <= "9") speed_run = next_whole(speed_run, ch[3:0]);
                else number_open[0] = 1'b0;
            end
            if (sep_total == 8 && number_open[1]) begin
                if (ch >= "0" && ch <= "9") course_run = next_whole(course_run, ch[3:0]);
                else number_open[1] = 1'b0;
            end
        end

        if (char_pos < MAX_SENTENCE + 1) char_pos++;

        if (last) begin
            len = int'(char_pos);
            hi  = hex_nibble(last_three[15:8]);
            lo  = hex_nibble(last_three[7:0]);
            if (len < 4 || len > MAX_SENTENCE || hi < 0 || lo < 0 ||
                ((hi << 4) | lo) != int'(sum_acc))
                rep.status = STATUS_BAD;
            else if (too_many_fields)
                rep.status = STATUS_OVERFLOW;
            else
                rep.status = STATUS_OK;
            rep.is_rmc       = (rep.status == STATUS_OK) && (len >= 6) && (type_hits == 3'b111);
            rep.fix_char     = rep.is_rmc ? fix_letter : 8'd0;
            rep.speed_whole  = rep.is_rmc ? speed_run : 16'd0;
            rep.course_whole = rep.is_rmc ? course_run : 16'd0;
            rep.field_total  = sep_total;
            rep.sum_seen     = sum_acc;
            if (want_status != NO_TYPED) rep.status = 2'(want_status);
            predicted_reports.push_back(rep);
            clear_parser();
        end
    endtask

    // ---------------------------------------------------------------
    // Sentence building
    // ---------------------------------------------------------------
    task automatic push_char(input logic [7:0] ch);
        sentence.push_back(ch);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) sentence.push_back(s[i]);
    endtask

    task automatic push_digits(input int count);
        repeat (count) push_char("0" + 8'($urandom_range(0, 9)));
    endtask

    function automatic logic [7:0] any_upper();
        return "A" + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
        if (nib < 4'd10) return "0" + 8'(nib);
        return (lower ? "a" : "A") + 8'(nib) - 8'd10;
    endfunction

    function automatic seal_t pick_seal();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return SEAL_UPPER;
        if (roll < 85) return SEAL_LOWER;
        if (roll < 93) return SEAL_WRONG;
        return SEAL_JUNK;
    endfunction

    // Close the sentence with '*' and a checksum pair, good or spoiled as asked.
    task automatic seal_sentence(input seal_t how);
        logic [7:0] sum;
        string      junk;
        bit         junk_high;

        junk = "GgZz*,. #";
        sum  = 8'd0;
        for (int i = 1; i < sentence.size(); i++) sum ^= sentence[i];
        if (how == SEAL_WRONG) sum ^= 8'($urandom_range(1, 255));
        push_char(CH_STAR);
        if (how == SEAL_JUNK) begin
            junk_high = 1'($urandom_range(0, 1));
            push_char(junk_high ? junk[$urandom_range(0, 8)] : hex_char(sum[7:4], 1'b0));
            push_char(junk_high ? hex_char(sum[3:0], 1'b0) : junk[$urandom_range(0, 8)]);
        end
        else begin
            push_char(hex_char(sum[7:4], how == SEAL_LOWER));
            push_char(hex_char(sum[3:0], how == SEAL_LOWER));
        end
    endtask

    // Speed or course content: often a plain number, some huge, some led by a non-digit, some empty or one random byte.
    task automatic push_number();
        string leads;
        int    roll;

        leads = "- +.A";
        roll  = $urandom_range(0, 99);
        if (roll >= 15 && roll < 65) begin
            push_digits($urandom_range(1, 4));
            if ($urandom_range(0, 1) == 1) begin
                push_char(".");
                push_digits($urandom_range(1, 2));
            end
        end
        else if (roll >= 65 && roll < 80) begin
            push_digits($urandom_range(5, 9));
        end
        else if (roll >= 80 && roll < 90) begin
            push_char(leads[$urandom_range(0, 4)]);
            push_digits(2);
        end
        else if (roll >= 90) begin
            push_char(8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly well-formed RMC sentences with random content; the rest other types,
    // truncated sentences, raw noise and sentences around the length limit.
    task automatic build_random_sentence();
        int roll;
        int cut;

        sentence.delete();
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            push_char("$");
            push_char(any_upper());
            push_char(any_upper());
            push_str("RMC");
            // spoil one letter of the type now and then
            if ($urandom_range(0, 9) == 0) sentence[3 + $urandom_range(0, 2)] = any_upper();
            push_char(CH_COMMA);
            push_digits($urandom_range(0, 6));
            push_char(CH_COMMA);
            cut = $urandom_range(0, 99);
            if (cut < 40) push_char("A");
            else if (cut < 70) push_char("V");
            else if (cut >= 85) push_char(8'($urandom_range(0, 255)));
            push_char(CH_COMMA);
            push_digits($urandom_range(0, 7));
            push_str(",N,");
            push_digits($urandom_range(0, 8));
            push_str(",E,");
            push_number();
            push_char(CH_COMMA);
            push_number();
            push_char(CH_COMMA);
            push_digits($urandom_range(0, 6));
            push_str(",,W");
            // rarely pile on separators to reach the field limit
            if ($urandom_range(0, 19) == 0) repeat ($urandom_range(8, 14)) push_char(CH_COMMA);
            seal_sentence(pick_seal());
            if ($urandom_range(0, 11) == 0) begin
                cut      = $urandom_range(1, sentence.size() - 1);
                sentence = sentence[0:cut - 1];
            end
        end
        else if (roll < 80) begin
            push_char("$");
            repeat (5) push_char(any_upper());
            cut = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 26) : $urandom_range(0, 12);
            repeat (cut) begin
                push_char(CH_COMMA);
                push_digits($urandom_range(0, 3));
            end
            seal_sentence(pick_seal());
        end
        else if (roll < 92) begin
            repeat ($urandom_range(1, 8)) push_char(8'($urandom_range(0, 255)));
        end
        else begin
            // target length straddles the longest legal sentence
            cut = $urandom_range(126, 150);
            push_str("$GPTXT,");
            while (sentence.size() < cut - 3) push_char(8'($urandom_range(32, 126)));
            seal_sentence(SEAL_UPPER);
        end
    endtask

    // ---------------------------------------------------------------
    // Character source
    // ---------------------------------------------------------------
    // Mostly no pause, sometimes a short one, rarely a long one.
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Entered at a falling edge; returns at the falling edge after the transfer.
    // Valid stays high between back-to-back characters, so it is never lowered
    // and raised again in the same step.
    task automatic send_char(input logic [7:0] ch, input logic last, input int want_status);
        int pause;
        pause = sender_steady ? 0 : pick_pause();
        if (pause > 0) begin
            chars_if.valid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.data_byte <= ch;
        chars_if.end_flag  <= last;
        @(posedge clk);
        while (!chars_if.ready) @(posedge clk);
        parse_char(ch, last, want_status);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_sentence(input int want_status);
        for (int i = 0; i < sentence.size(); i++)
            send_char(sentence[i], i == sentence.size() - 1, want_status);
    endtask

    // Hold the source off until every outstanding report has come back.
    task automatic drain_reports();
        chars_if.valid <= 1'b0;
        while (predicted_reports.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    initial begin : stimulus
        chars_if.valid     = 1'b0;
        chars_if.data_byte = 8'd0;
        chars_if.end_flag  = 1'b0;
        clear_parser();

        // hold reset, then release it on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (directed_rows[i]) begin
            sentence.delete();
            push_str(directed_rows[i].text);
            repeat (directed_rows[i].fill_count) push_str(directed_rows[i].fill);
            if (directed_rows[i].seal != SEAL_NONE) seal_sentence(directed_rows[i].seal);
            send_sentence(directed_rows[i].want_status);
        end
        drain_reports();

        // random sentences; switch the source between bursty and steady now and then
        chars_sent = 0;
        while (chars_sent < RANDOM_CHARS) begin
            build_random_sentence();
            send_sentence(NO_TYPED);
            if ($urandom_range(0, 24) == 0) drain_reports();
            if ($urandom_range(0, 9) == 0) sender_steady = !sender_steady;
        end

        // drop valid, wait out the last reports, then let the pipeline settle
        chars_if.valid <= 1'b0;
        while (predicted_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------
    // Report sink and checker
    // ---------------------------------------------------------------
    initial begin : report_sink
        int stall;
        stall = 0;
        reports_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 199) == 0) sink_steady = !sink_steady;
            if (stall > 0) begin
                reports_if.ready <= 1'b0;
                stall--;
            end
            else begin
                reports_if.ready <= 1'b1;
                stall = sink_steady ? 0 : pick_pause();
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Compare each report transfer, field by field, with the oldest prediction.
    always @(posedge clk) begin : report_check
        nsc_result_t want;
        if (rst_n && reports_if.valid && reports_if.ready) begin
            if (predicted_reports.size() == 0) begin
                $display("%0t ns: unexpected report, status %0h sum_seen %0h",
                         $time, reports_if.status, reports_if.sum_seen);
                error_count++;
            end
            else begin
                want = predicted_reports.pop_front();
                check_field("status", 32'(want.status), 32'(reports_if.status));
                check_field("is_rmc", 32'(want.is_rmc), 32'(reports_if.is_rmc));
                check_field("fix_char", 32'(want.fix_char), 32'(reports_if.fix_char));
                check_field("speed_whole", 32'(want.speed_whole), 32'(reports_if.speed_whole));
                check_field("course_whole", 32'(want.course_whole),
                            32'(reports_if.course_whole));
                check_field("field_total", 32'(want.field_total), 32'(reports_if.field_total));
                check_field("sum_seen", 32'(want.sum_seen), 32'(reports_if.sum_seen));
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
